// ----- rtl/crs_pkg.sv -----
// Shared types and codes for the component recovery supervisor.
package crs_pkg;

	localparam int unsigned MAX_COMP    = 8;
	localparam int unsigned MAX_RETRIES = 3;

	// recovery phase codes
	localparam logic [2:0] PH_NOMINAL        = 3'd0;
	localparam logic [2:0] PH_POWER_OFF      = 3'd1;
	localparam logic [2:0] PH_WAIT_DISCHARGE = 3'd2;
	localparam logic [2:0] PH_POWER_ON       = 3'd3;
	localparam logic [2:0] PH_WAIT_BOOT      = 3'd4;
	localparam logic [2:0] PH_DEFECTIVE      = 3'd5;

	// requested actions
	localparam logic [2:0] ACT_NONE        = 3'd0;
	localparam logic [2:0] ACT_CONFIGURE   = 3'd1;
	localparam logic [2:0] ACT_ACTIVATE    = 3'd2;
	localparam logic [2:0] ACT_CLEANUP     = 3'd3;
	localparam logic [2:0] ACT_RELAY_OPEN  = 3'd4;
	localparam logic [2:0] ACT_RELAY_CLOSE = 3'd5;

	// reported lifecycle state
	localparam logic [1:0] RS_ACTIVE   = 2'd0;
	localparam logic [1:0] RS_UNCONF   = 2'd1;
	localparam logic [1:0] RS_INACTIVE = 2'd2;
	localparam logic [1:0] RS_FAILED   = 2'd3;

	// pass health
	localparam logic [1:0] HL_OK        = 2'd0;
	localparam logic [1:0] HL_RECOVER   = 2'd1;
	localparam logic [1:0] HL_EMERGENCY = 2'd2;

	// config register indexes
	localparam logic [1:0] CFG_ENABLE    = 2'd0;
	localparam logic [1:0] CFG_RELAY     = 2'd1;
	localparam logic [1:0] CFG_POWER_OFF = 2'd2;
	localparam logic [1:0] CFG_STARTUP   = 2'd3;

	localparam logic [15:0] POWER_OFF_RESET = 16'd30;
	localparam logic [3:0]  RETRY_SAT       = 4'hF;

	typedef struct packed {
		logic [2:0]  component;
		logic [1:0]  reported_state;
		logic [15:0] now_tick;
		logic        end_of_pass;
	} crs_item_t;

	typedef struct packed {
		logic [2:0]  phase;
		logic [3:0]  retries;
		logic        defective;
		logic [15:0] start_tick;
	} crs_entry_t;

	typedef struct packed {
		logic all_clean;
		logic any_defective;
	} crs_pass_t;

	// table and config view for the addressed component
	typedef struct packed {
		crs_entry_t  entry;
		logic        in_range;
		logic        enabled;
		logic        relay;
		logic [15:0] power_off_ticks;
		logic [7:0]  boot_ticks;
		crs_pass_t   pass;
	} crs_view_t;

	typedef struct packed {
		logic       wr_en;
		crs_entry_t entry;
		crs_pass_t  pass;
	} crs_update_t;

	typedef struct packed {
		logic [2:0] action;
		logic [2:0] new_phase;
		logic       locked_out;
		logic [3:0] retries_used;
		logic       pass_done;
		logic [1:0] health;
		logic       cut_power;
	} crs_result_t;

endpackage

// ----- rtl/crs_step.sv -----
// Per-report decision logic: recovery step, entry update and pass health.
module crs_step import crs_pkg::*; (
	input  crs_item_t   item,
	input  crs_view_t   view,
	output crs_update_t upd,
	output crs_result_t res
);

	crs_entry_t  e;
	logic [2:0]  act;
	logic        all_act;
	logic        any_def;
	logic [15:0] elapsed;
	logic [3:0]  retry_inc;
	logic [1:0]  health;

	assign elapsed   = item.now_tick - view.entry.start_tick;
	assign retry_inc = (view.entry.retries != RETRY_SAT) ? view.entry.retries + 4'd1
	                                                     : view.entry.retries;

	always_comb begin
		e       = view.entry;
		act     = ACT_NONE;
		all_act = view.pass.all_clean;
		any_def = view.pass.any_defective;
		if (view.in_range && view.enabled) begin
			if (view.entry.defective) begin
				all_act = 1'b0;
				any_def = 1'b1;
			end else begin
				unique case (item.reported_state)
					RS_ACTIVE: begin
						e.retries = 4'd0;
						e.phase   = PH_NOMINAL;
					end
					RS_UNCONF: begin
						all_act = 1'b0;
						act     = ACT_CONFIGURE;
					end
					RS_INACTIVE: begin
						all_act = 1'b0;
						act     = ACT_ACTIVATE;
					end
					RS_FAILED: begin
						all_act = 1'b0;
						unique case (view.entry.phase)
							PH_NOMINAL: begin
								e.retries = retry_inc;
								if (retry_inc > 4'(MAX_RETRIES)) begin
									e.defective = 1'b1;
									e.phase     = PH_DEFECTIVE;
								end else begin
									e.phase = PH_POWER_OFF;
								end
							end
							PH_POWER_OFF: begin
								act          = view.relay ? ACT_RELAY_OPEN : ACT_CLEANUP;
								e.phase      = PH_WAIT_DISCHARGE;
								e.start_tick = item.now_tick;
							end
							PH_WAIT_DISCHARGE: begin
								if (elapsed >= view.power_off_ticks)
									e.phase = PH_POWER_ON;
							end
							PH_POWER_ON: begin
								act          = view.relay ? ACT_RELAY_CLOSE : ACT_NONE;
								e.phase      = PH_WAIT_BOOT;
								e.start_tick = item.now_tick;
							end
							PH_WAIT_BOOT: begin
								if (elapsed >= {8'd0, view.boot_ticks}) begin
									e.phase      = PH_NOMINAL;
									e.start_tick = item.now_tick;
								end
							end
							PH_DEFECTIVE: begin
							end
							default: begin
								// stray phase code: lock out
								e.defective = 1'b1;
								e.phase     = PH_DEFECTIVE;
							end
						endcase
						if (e.defective)
							any_def = 1'b1;
					end
				endcase
			end
		end
	end

	assign health = all_act ? HL_OK : (any_def ? HL_EMERGENCY : HL_RECOVER);

	assign upd.wr_en              = view.in_range && view.enabled;
	assign upd.entry              = e;
	assign upd.pass.all_clean     = item.end_of_pass ? 1'b1 : all_act;
	assign upd.pass.any_defective = item.end_of_pass ? 1'b0 : any_def;

	assign res.action       = act;
	assign res.new_phase    = view.in_range ? e.phase : 3'd0;
	assign res.locked_out   = view.in_range ? e.defective : 1'b0;
	assign res.retries_used = view.in_range ? e.retries : 4'd0;
	assign res.pass_done    = item.end_of_pass;
	assign res.health       = item.end_of_pass ? health : HL_OK;
	assign res.cut_power    = item.end_of_pass && (health == HL_EMERGENCY);

endmodule

// ----- rtl/crs_state.sv -----
// Config registers, per-component recovery table and pass flags.
module crs_state import crs_pkg::*; #(
	parameter int unsigned NUM_COMPONENTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic [2:0]  component,
	input  logic        commit,
	input  crs_update_t upd,
	output crs_view_t   view
);

	logic [MAX_COMP-1:0]       enable_q;
	logic [MAX_COMP-1:0]       relay_q;
	logic [15:0]               power_off_q;
	logic [MAX_COMP-1:0][7:0]  startup_q;
	crs_entry_t                entry_q [NUM_COMPONENTS];
	crs_pass_t                 pass_q;
	crs_entry_t                entry_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= '0;
			relay_q     <= '0;
			power_off_q <= POWER_OFF_RESET;
			startup_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ENABLE:    enable_q    <= cfg_data[7:0];
				CFG_RELAY:     relay_q     <= cfg_data[7:0];
				CFG_POWER_OFF: power_off_q <= cfg_data[15:0];
				CFG_STARTUP:   startup_q   <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COMPONENTS; i++)
				entry_q[i] <= '0;
			pass_q <= '{all_clean: 1'b1, any_defective: 1'b0};
		end else if (commit) begin
			for (int i = 0; i < NUM_COMPONENTS; i++)
				if (upd.wr_en && component == 3'(i))
					entry_q[i] <= upd.entry;
			pass_q <= upd.pass;
		end
	end

	always_comb begin
		entry_sel = '0;
		for (int i = 0; i < NUM_COMPONENTS; i++)
			if (component == 3'(i))
				entry_sel = entry_q[i];
	end

	assign view.entry           = entry_sel;
	assign view.in_range        = {1'b0, component} < 4'(NUM_COMPONENTS);
	assign view.enabled         = enable_q[component];
	assign view.relay           = relay_q[component];
	assign view.power_off_ticks = power_off_q;
	assign view.boot_ticks      = startup_q[component];
	assign view.pass            = pass_q;

endmodule

// ----- rtl/component_recovery_supervisor.sv -----
// Top level of the component recovery supervisor: stream ports and word pipeline.
// Each word on the input stream is one health report for a component; it is
// registered, run through the recovery step against that component's table
// entry, and its result lands in an output register once that slot is free, so the
// result word follows the report through the input and output registers, and one report
// is taken every cycle as long as the output side keeps up (the table
// read-modify-write for a report commits in the same edge that loads the
// result, so the next report already sees it). The output register parts the
// two sides: one new report is taken while a finished result still waits.
// Reports for a component at or above NUM_COMPONENTS, or whose enable bit is
// clear, change no table entry and, unless they end a pass, no pass flag.
// Configuration is written through cfg_we/cfg_index/cfg_data and must only be
// changed while no reports are in flight.
module component_recovery_supervisor import crs_pkg::*; #(
	parameter int unsigned NUM_COMPONENTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // component[2:0], reported_state[4:3], now_tick[20:5]
	input  logic        s_tlast,   // end_of_pass
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // action[2:0], new_phase[5:3], locked_out[6],
	                               // retries_used[10:7], health[12:11], cut_power[13]
	output logic        m_tlast    // pass_done
);

	logic        in_vld_s1;
	crs_item_t   item_s1;
	logic        res_vld_s2;
	crs_result_t res_s2;
	logic        adv;
	crs_view_t   view;
	crs_update_t upd;
	crs_result_t res;

	// step fires when a report is held and the result slot frees up
	assign adv      = in_vld_s1 && (!res_vld_s2 || m_tready);
	assign s_tready = !in_vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_vld_s1 <= 1'b0;
		end else if (s_tready) begin
			in_vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.component      <= s_tdata[2:0];
			item_s1.reported_state <= s_tdata[4:3];
			item_s1.now_tick       <= s_tdata[20:5];
			item_s1.end_of_pass    <= s_tlast;
		end
	end

	crs_state #(
		.NUM_COMPONENTS(NUM_COMPONENTS)
	) u_state (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.component(item_s1.component),
		.commit   (adv),
		.upd      (upd),
		.view     (view)
	);

	crs_step u_step (
		.item(item_s1),
		.view(view),
		.upd (upd),
		.res (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_s2 <= 1'b0;
		end else if (adv) begin
			res_vld_s2 <= 1'b1;
		end else if (m_tready) begin
			res_vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_s2 <= res;
	end

	assign m_tvalid = res_vld_s2;
	assign m_tdata  = {2'b00, res_s2.cut_power, res_s2.health, res_s2.retries_used,
	                   res_s2.locked_out, res_s2.new_phase, res_s2.action};
	assign m_tlast  = res_s2.pass_done;

	// pass flags return to their idle values once a pass closes
	a_pass_clear: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item_s1.end_of_pass |=> view.pass.all_clean && !view.pass.any_defective)
		else $error("pass flags not cleared after end of pass");

	a_cut_power: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_s2 && res_s2.cut_power |-> res_s2.pass_done && res_s2.health == HL_EMERGENCY)
		else $error("cut_power without emergency close");

	a_lock_phase: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_s2 && res_s2.locked_out |-> res_s2.new_phase == PH_DEFECTIVE)
		else $error("locked-out component not in defective phase");

	a_retry_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_s2 |-> res_s2.retries_used <= 4'(MAX_RETRIES + 1))
		else $error("retry count past lockout bound");

endmodule
